// File: sv/ghh_pkg.sv
// Shared types, constants and helpers for the heading-hold drive block.
// No dependencies; every other file refers to this package by scoped name.
package ghh_pkg;

	// field widths
	localparam int RATE_W    = 16;
	localparam int DRV_W     = 16;
	localparam int HEAD_W    = 48;
	localparam int RAMP_W    = 32;
	localparam int ELAPSED_W = 17;
	localparam int DIF_W     = 43;
	localparam int LR_W      = 44;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	// 2^40 in Q.16, the clamp on the heading term magnitude
	localparam logic [40:0] DIF_LIM = 41'h100_0000_0000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_SPEED = 3'd0,
		REG_RUN_TIME_MS  = 3'd1,
		REG_GAIN_P       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_RAMP_KEEP    = 3'd4,
		REG_STOP_ON_LINE = 3'd5
	} cfg_reg_t;

	// input word kinds
	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_START = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic signed [15:0] target_speed;
		logic [15:0]        run_time_ms;
		logic [23:0]        gain_p;
		logic [23:0]        gain_d;
		logic [15:0]        ramp_keep;
		logic               stop_on_line;
	} cfg_t;

	typedef struct packed {
		logic drive_en;
		logic move_done;
		logic idle;
	} flags_t;

	// word leaving the tracking stage
	typedef struct packed {
		flags_t                    flags;
		logic signed [HEAD_W-1:0]  heading;
		logic signed [RATE_W-1:0]  rate;
		logic signed [RAMP_W-1:0]  ramp;
	} trk_t;

	// word leaving the correction pipeline
	typedef struct packed {
		flags_t                    flags;
		logic signed [DIF_W-1:0]   dif;
		logic signed [RAMP_W-1:0]  ramp;
	} corr_t;

	// Q.16 to integer, truncated toward zero, then saturated to 16 bits
	function automatic logic signed [DRV_W-1:0] drive_sat(input logic signed [LR_W-1:0] v);
		logic signed [LR_W-1:0]  adj;
		logic signed [LR_W-17:0] q;
		adj = v[LR_W-1] ? (v + LR_W'(16'hFFFF)) : v;
		q   = adj[LR_W-1:16];
		if (q > 32767)
			return 16'sh7FFF;
		else if (q < -32768)
			return 16'sh8000;
		else
			return q[DRV_W-1:0];
	endfunction

endpackage

// File: sv/ghh_sample_if.sv
// Input channel: one word per tick or move start.
// Depends on ghh_pkg for widths.
interface ghh_sample_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic signed [ghh_pkg::RATE_W-1:0] gyro_rate;
	logic                              line_reached;

	modport source (output valid, kind, gyro_rate, line_reached, input ready);
	modport sink   (input valid, kind, gyro_rate, line_reached, output ready);
endinterface

// File: sv/ghh_result_if.sv
// Output channel: one drive word per input word.
// Depends on ghh_pkg for widths.
interface ghh_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [ghh_pkg::DRV_W-1:0] left_drive;
	logic signed [ghh_pkg::DRV_W-1:0] right_drive;
	logic                             move_done;
	logic                             idle;

	modport source (output valid, left_drive, right_drive, move_done, idle, input ready);
	modport sink   (input valid, left_drive, right_drive, move_done, idle, output ready);
endinterface

// File: sv/ghh_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on ghh_pkg for widths.
interface ghh_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ghh_pkg::CFG_IDX_W-1:0]    index;
	logic [ghh_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/ghh_cfg_regs.sv
// Configuration register file for the heading-hold drive.
// Depends on ghh_pkg and ghh_cfg_if.
module ghh_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	ghh_cfg_if.sink        cfg,
	output ghh_pkg::cfg_t  regs
);

	ghh_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_speed <= 16'sd60;
			regs_q.run_time_ms  <= 16'd100;
			regs_q.gain_p       <= 24'd5033;
			regs_q.gain_d       <= 24'd16777;
			regs_q.ramp_keep    <= 16'd52429;
			regs_q.stop_on_line <= 1'b0;
		end else if (cfg.valid) begin
			case (ghh_pkg::cfg_reg_t'(cfg.index))
				ghh_pkg::REG_TARGET_SPEED: regs_q.target_speed <= $signed(cfg.data[15:0]);
				ghh_pkg::REG_RUN_TIME_MS:  regs_q.run_time_ms  <= cfg.data[15:0];
				ghh_pkg::REG_GAIN_P:       regs_q.gain_p       <= cfg.data[23:0];
				ghh_pkg::REG_GAIN_D:       regs_q.gain_d       <= cfg.data[23:0];
				ghh_pkg::REG_RAMP_KEEP:    regs_q.ramp_keep    <= cfg.data[15:0];
				ghh_pkg::REG_STOP_ON_LINE: regs_q.stop_on_line <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// File: sv/ghh_track.sv
// Input register and move state: heading sum, speed ramp, elapsed time.
// Depends on ghh_pkg and ghh_sample_if.
module ghh_track #(
	parameter int TICK_MS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	ghh_sample_if.sink     sample,
	input  ghh_pkg::cfg_t  regs,
	output logic           dn_valid,
	input  logic           dn_ready,
	output ghh_pkg::trk_t  dn_word
);

	// input register
	logic                              v_s1;
	ghh_pkg::item_kind_t               kind_s1;
	logic signed [ghh_pkg::RATE_W-1:0] rate_s1;
	logic                              line_s1;
	logic                              rdy_s1;

	// output register
	logic          v_s2;
	ghh_pkg::trk_t trk_s2;
	logic          rdy_s2;

	// move state
	logic signed [ghh_pkg::HEAD_W-1:0]  heading_q, heading_n, heading_add;
	logic signed [ghh_pkg::RAMP_W-1:0]  ramp_q, ramp_n, ramp_upd;
	logic [ghh_pkg::ELAPSED_W-1:0]      elapsed_q, elapsed_n, elapsed_upd;
	logic                               running_q, running_n;
	logic [ghh_pkg::ELAPSED_W:0]        elapsed_sum;
	logic                               upd;
	logic                               zero_move;
	logic                               done;
	ghh_pkg::trk_t                      trk_n;

	// ramp blend terms
	logic [16:0]        keep_cmp;
	logic signed [48:0] keep_prod;
	logic signed [33:0] pull_prod;
	logic signed [49:0] blend, blend_adj;

	assign rdy_s2       = !v_s2 || dn_ready;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign upd          = v_s1 && rdy_s2;
	assign sample.ready = rdy_s1;
	assign dn_valid     = v_s2;
	assign dn_word      = trk_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy_s1)
			v_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && rdy_s1) begin
			kind_s1 <= ghh_pkg::item_kind_t'(sample.kind);
			rate_s1 <= sample.gyro_rate;
			line_s1 <= sample.line_reached;
		end
	end

	// heading integration, wraps in 48 bits
	assign heading_add = heading_q + ghh_pkg::HEAD_W'(rate_s1);

	// first-order ramp: (keep*ramp + (1-keep)*target*2^16) / 2^16, toward zero
	assign keep_cmp  = 17'h1_0000 - {1'b0, regs.ramp_keep};
	assign keep_prod = $signed({1'b0, regs.ramp_keep}) * ramp_q;
	assign pull_prod = $signed({1'b0, keep_cmp}) * regs.target_speed;
	assign blend     = 50'(keep_prod) + (50'(pull_prod) <<< 16);
	assign blend_adj = blend[49] ? (blend + 50'sd65535) : blend;
	assign ramp_upd  = blend_adj[47:16];

	// elapsed time, saturating
	assign elapsed_sum = {1'b0, elapsed_q} + (ghh_pkg::ELAPSED_W + 1)'(TICK_MS);
	assign elapsed_upd = (elapsed_sum > {1'b0, ghh_pkg::ELAPSED_MAX}) ?
		ghh_pkg::ELAPSED_MAX : elapsed_sum[ghh_pkg::ELAPSED_W-1:0];

	// next state and word for the correction pipeline
	always_comb begin
		heading_n  = heading_q;
		ramp_n     = ramp_q;
		elapsed_n  = elapsed_q;
		running_n  = running_q;
		zero_move  = (regs.target_speed == 16'sd0) || (regs.run_time_ms == 16'd0);
		done       = (elapsed_upd >= ghh_pkg::ELAPSED_W'(regs.run_time_ms)) ||
			(regs.stop_on_line && line_s1);
		trk_n.flags   = '0;
		trk_n.heading = heading_add;
		trk_n.rate    = rate_s1;
		trk_n.ramp    = ramp_upd;
		if (kind_s1 == ghh_pkg::KIND_START) begin
			heading_n = '0;
			ramp_n    = '0;
			elapsed_n = '0;
			running_n = !zero_move;
			trk_n.flags.move_done = zero_move;
			trk_n.flags.idle      = zero_move;
		end else if (!running_q) begin
			trk_n.flags.idle = 1'b1;
		end else begin
			heading_n = heading_add;
			ramp_n    = ramp_upd;
			elapsed_n = elapsed_upd;
			running_n = !done;
			trk_n.flags.drive_en  = 1'b1;
			trk_n.flags.move_done = done;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			ramp_q    <= '0;
			elapsed_q <= '0;
			running_q <= 1'b0;
		end else if (upd) begin
			heading_q <= heading_n;
			ramp_q    <= ramp_n;
			elapsed_q <= elapsed_n;
			running_q <= running_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2)
			trk_s2 <= trk_n;
	end

	// a move stops only while a word is taken through the state stage
	a_stop_on_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> $past(upd))
		else $error("running cleared without a word");

	// state holds between words
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(heading_q) && $stable(ramp_q) && $stable(elapsed_q))
		else $error("move state changed without a word");

endmodule

// File: sv/ghh_corr.sv
// PD heading correction: gain products, clamp and sum of both terms.
// Depends on ghh_pkg.
module ghh_corr (
	input  logic            clk,
	input  logic            arst_n,
	input  ghh_pkg::cfg_t   regs,
	input  logic            up_valid,
	output logic            up_ready,
	input  ghh_pkg::trk_t   up_word,
	output logic            dn_valid,
	input  logic            dn_ready,
	output ghh_pkg::corr_t  dn_word
);

	logic rdy_s3, rdy_s4;
	logic v_s3, v_s4;

	// stage 3 registers: raw products
	logic [47:0]                       hi_p_s3, lo_p_s3;
	logic [39:0]                       d_prod_s3;
	logic                              head_neg_s3, rate_neg_s3;
	ghh_pkg::flags_t                   flags_s3;
	logic signed [ghh_pkg::RAMP_W-1:0] ramp_s3;

	ghh_pkg::corr_t corr_s4;

	// products
	logic [ghh_pkg::HEAD_W-1:0] head_abs;
	logic [ghh_pkg::RATE_W-1:0] rate_abs;
	logic [47:0]                hi_p, lo_p;
	logic [39:0]                d_prod;

	// clamp and sum
	logic [40:0]                      m_p, mag_p;
	logic [31:0]                      mag_d;
	logic signed [41:0]               term_p;
	logic signed [32:0]               term_d;
	logic signed [ghh_pkg::DIF_W-1:0] dif;

	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign up_ready = rdy_s3;
	assign dn_valid = v_s4;
	assign dn_word  = corr_s4;

	// magnitudes, then the gain products split at bit 24 of the heading
	assign head_abs = up_word.heading[ghh_pkg::HEAD_W-1] ?
		(~up_word.heading + 1'b1) : up_word.heading;
	assign rate_abs = up_word.rate[ghh_pkg::RATE_W-1] ?
		(~up_word.rate + 1'b1) : up_word.rate;
	assign hi_p   = head_abs[47:24] * regs.gain_p;
	assign lo_p   = head_abs[23:0] * regs.gain_p;
	assign d_prod = rate_abs * regs.gain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= up_valid;
			if (rdy_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			hi_p_s3     <= hi_p;
			lo_p_s3     <= lo_p;
			d_prod_s3   <= d_prod;
			head_neg_s3 <= up_word.heading[ghh_pkg::HEAD_W-1];
			rate_neg_s3 <= up_word.rate[ghh_pkg::RATE_W-1];
			flags_s3    <= up_word.flags;
			ramp_s3     <= up_word.ramp;
		end
	end

	// heading term magnitude in Q.16, clamped to 2^40
	always_comb begin
		m_p = {1'b0, hi_p_s3[23:0], 16'h0000} + {1'b0, lo_p_s3[47:8]};
		if (hi_p_s3[47:24] != 24'd0)
			mag_p = ghh_pkg::DIF_LIM;
		else if (m_p > ghh_pkg::DIF_LIM)
			mag_p = ghh_pkg::DIF_LIM;
		else
			mag_p = m_p;
	end

	// both terms are negated products
	assign mag_d  = d_prod_s3[39:8];
	assign term_p = head_neg_s3 ? $signed({1'b0, mag_p}) : -$signed({1'b0, mag_p});
	assign term_d = rate_neg_s3 ? $signed({1'b0, mag_d}) : -$signed({1'b0, mag_d});
	assign dif    = ghh_pkg::DIF_W'(term_p) + ghh_pkg::DIF_W'(term_d);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			corr_s4.flags <= flags_s3;
			corr_s4.dif   <= dif;
			corr_s4.ramp  <= ramp_s3;
		end
	end

endmodule

// File: sv/ghh_drive_out.sv
// Left/right drive mix, truncation and saturation, and the result register.
// Depends on ghh_pkg and ghh_result_if.
module ghh_drive_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  ghh_pkg::corr_t  up_word,
	ghh_result_if.source    result
);

	logic                              v_o;
	logic                              rdy_o;
	logic signed [ghh_pkg::LR_W-1:0]   left_q16, right_q16;
	logic signed [ghh_pkg::DRV_W-1:0]  left_q, right_q;
	logic                              done_q, idle_q;

	assign rdy_o    = !v_o || result.ready;
	assign up_ready = rdy_o;

	// ramp minus and plus the correction
	assign left_q16  = ghh_pkg::LR_W'(up_word.ramp) - ghh_pkg::LR_W'(up_word.dif);
	assign right_q16 = ghh_pkg::LR_W'(up_word.ramp) + ghh_pkg::LR_W'(up_word.dif);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_o <= 1'b0;
		else if (rdy_o)
			v_o <= up_valid;
	end

	// zero drive unless a running tick made this word
	always_ff @(posedge clk) begin
		if (rdy_o) begin
			left_q  <= up_word.flags.drive_en ? ghh_pkg::drive_sat(left_q16) : '0;
			right_q <= up_word.flags.drive_en ? ghh_pkg::drive_sat(right_q16) : '0;
			done_q  <= up_word.flags.move_done;
			idle_q  <= up_word.flags.idle;
		end
	end

	assign result.valid       = v_o;
	assign result.left_drive  = left_q;
	assign result.right_drive = right_q;
	assign result.move_done   = done_q;
	assign result.idle        = idle_q;

endmodule

// File: sv/gyro_heading_hold_drive_unit.sv
// Heading-hold drive: latency is five register stages, from the input register to the
// result register. Throughput is one word per cycle while the result side is ready,
// bounded by the ramp feedback (one multiply and add per cycle in the state stage).
// Asynchronous active-low reset clears the move state and pipeline valids and
// loads the configuration defaults; the block is ready straight after reset.
module gyro_heading_hold_drive_unit #(
	parameter int TICK_MS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	ghh_sample_if.sink    sample,
	ghh_result_if.source  result,
	ghh_cfg_if.sink       cfg
);

	ghh_pkg::cfg_t  regs;
	logic           trk_valid, trk_ready;
	ghh_pkg::trk_t  trk_word;
	logic           corr_valid, corr_ready;
	ghh_pkg::corr_t corr_word;

	ghh_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ghh_track #(.TICK_MS(TICK_MS)) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.regs     (regs),
		.dn_valid (trk_valid),
		.dn_ready (trk_ready),
		.dn_word  (trk_word)
	);

	ghh_corr u_corr (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.up_valid (trk_valid),
		.up_ready (trk_ready),
		.up_word  (trk_word),
		.dn_valid (corr_valid),
		.dn_ready (corr_ready),
		.dn_word  (corr_word)
	);

	ghh_drive_out u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (corr_valid),
		.up_ready (corr_ready),
		.up_word  (corr_word),
		.result   (result)
	);

	// an idle word never carries drive
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.idle |-> result.left_drive == '0 && result.right_drive == '0)
		else $error("drive on an idle word");

	// with the result register empty the whole pipeline can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("input stalled with empty result register");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the heading-hold drive unit: predicts every drive word
// from the sample words it accepts. Depends on ghh_pkg and the three channel interfaces.
module tb;

	localparam int          RUN_LIMIT   = 200000;
	localparam int          HOLD_CYCLES = 80;
	localparam logic [2:0]  SPARE_REG   = 3'd6;    // index with no register behind it
	localparam longint      TERM_LIM    = 64'sd1 << 40;
	localparam int          ELAPSED_TOP = 131071;

	typedef struct {
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
		logic               move_done;
		logic               idle;
	} drive_word_t;

	// predicts the drive word for each accepted sample word and checks the results
	class drive_tracker;
		longint             target_speed;
		longint             run_time_ms;
		longint             gain_p;
		longint             gain_d;
		longint             ramp_keep;
		bit                 stop_on_line;
		logic signed [47:0] heading_sum;
		longint             ramp_speed;
		int                 elapsed_ms;
		bit                 running;
		drive_word_t        drive_due[$];
		int                 fail_count;

		function new();
			target_speed = 60;
			run_time_ms  = 100;
			gain_p       = 5033;
			gain_d       = 16777;
			ramp_keep    = 52429;
			stop_on_line = 0;
			heading_sum  = '0;
			ramp_speed   = 0;
			elapsed_ms   = 0;
			running      = 0;
			fail_count   = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [23:0] data);
			logic signed [15:0] s16;
			s16 = data[15:0];
			case (idx)
				ghh_pkg::REG_TARGET_SPEED: target_speed = s16;
				ghh_pkg::REG_RUN_TIME_MS:  run_time_ms  = data[15:0];
				ghh_pkg::REG_GAIN_P:       gain_p       = data;
				ghh_pkg::REG_GAIN_D:       gain_d       = data;
				ghh_pkg::REG_RAMP_KEEP:    ramp_keep    = data[15:0];
				ghh_pkg::REG_STOP_ON_LINE: stop_on_line = data[0];
				default: ;
			endcase
		endfunction

		// -(g * x) in Q.16, magnitude truncated and clamped
		function longint neg_term(longint g, longint x);
			longint unsigned a, hi, lo, m;
			longint          mag;
			a  = (x < 0) ? -x : x;
			hi = (a >> 24) * g;
			lo = (a & 64'hFF_FFFF) * g;
			if (hi >= (64'd1 << 24)) begin
				mag = TERM_LIM;
			end else begin
				m   = (hi << 16) + (lo >> 8);
				mag = (m > TERM_LIM) ? TERM_LIM : longint'(m);
			end
			return (x < 0) ? mag : -mag;
		endfunction

		// Q.16 to integer toward zero, then clipped to 16 bits
		function logic signed [15:0] to_drive(longint q);
			longint v;
			v = q / 65536;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return v[15:0];
		endfunction

		function void note_word(logic kind, logic signed [15:0] rate, logic line);
			drive_word_t w;
			longint      dif;
			longint      blend;
			w = '{left_drive: '0, right_drive: '0, move_done: 1'b0, idle: 1'b0};
			if (kind == ghh_pkg::KIND_START) begin
				heading_sum = '0;
				ramp_speed  = 0;
				elapsed_ms  = 0;
				// zero speed or zero time finishes the move on the spot
				if (target_speed == 0 || run_time_ms == 0) begin
					running     = 0;
					w.move_done = 1'b1;
					w.idle      = 1'b1;
				end else begin
					running = 1;
				end
			end else if (!running) begin
				w.idle = 1'b1;
			end else begin
				heading_sum = heading_sum + rate;
				dif = neg_term(gain_p, longint'(heading_sum)) + neg_term(gain_d, longint'(rate));
				blend = ramp_keep * ramp_speed + (65536 - ramp_keep) * target_speed * 65536;
				ramp_speed = blend / 65536;
				w.left_drive  = to_drive(ramp_speed - dif);
				w.right_drive = to_drive(ramp_speed + dif);
				elapsed_ms = (elapsed_ms > ELAPSED_TOP - 10) ? ELAPSED_TOP : elapsed_ms + 10;
				if (elapsed_ms >= run_time_ms || (stop_on_line && line)) begin
					running     = 0;
					w.move_done = 1'b1;
				end
			end
			drive_due.push_back(w);
		endfunction

		function void check_word(logic signed [15:0] l, logic signed [15:0] r, logic done,
				logic idl);
			drive_word_t w;
			if (drive_due.size() == 0) begin
				$error("drive word arrived with none outstanding");
				fail_count++;
				return;
			end
			w = drive_due.pop_front();
			if (l !== w.left_drive) begin
				$error("left_drive: expected %0d, got %0d", w.left_drive, l);
				fail_count++;
			end
			if (r !== w.right_drive) begin
				$error("right_drive: expected %0d, got %0d", w.right_drive, r);
				fail_count++;
			end
			if (done !== w.move_done) begin
				$error("move_done: expected %0b, got %0b", w.move_done, done);
				fail_count++;
			end
			if (idl !== w.idle) begin
				$error("idle: expected %0b, got %0b", w.idle, idl);
				fail_count++;
			end
		endfunction

		function int waiting();
			return drive_due.size();
		endfunction

		function void close_out();
			if (drive_due.size() != 0) begin
				$error("%0d drive words never arrived", drive_due.size());
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ghh_sample_if smp();
	ghh_result_if res();
	ghh_cfg_if    cfg_ch();

	gyro_heading_hold_drive_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg_ch)
	);

	drive_tracker sb;
	bit           calm;          // no idling on either side
	int           stall_asks;    // bumped by the sender to ask for a long hold-off
	int           stall_seen;
	int           stall_left;
	int           cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// result side: check accepted words, then choose ready for the next cycle
	always @(posedge clk) begin
		if (res.valid && res.ready)
			sb.check_word(res.left_drive, res.right_drive, res.move_done, res.idle);
		if (stall_asks != stall_seen) begin
			stall_seen = stall_asks;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			res.ready <= 1'b0;
		end else if (calm) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= ($urandom_range(99) >= 24);
		end
	end

	task automatic send_word(logic kind, logic signed [15:0] rate, logic line);
		if (!calm) begin
			while ($urandom_range(99) < 24) begin
				smp.valid <= 1'b0;
				@(posedge clk);
			end
		end
		smp.kind         <= kind;
		smp.gyro_rate    <= rate;
		smp.line_reached <= line;
		smp.valid        <= 1'b1;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		sb.note_word(kind, rate, line);
	endtask

	// stop offering and wait for every outstanding drive word
	task automatic drain();
		smp.valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] data);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic cfg_close();
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_rate();
		case ($urandom_range(9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3, 4: return 16'($signed($urandom_range(400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] pick_gain();
		case ($urandom_range(7))
			0:       return 24'd0;
			1:       return 24'hFF_FFFF;
			2:       return 24'($urandom);
			default: return 24'($urandom_range(40000));
		endcase
	endfunction

	// fresh setting of every register; spare upper data bits are random
	task automatic random_config();
		logic [15:0] v16;
		case ($urandom_range(7))
			0:       v16 = 16'h8000;
			1:       v16 = 16'h7FFF;
			2:       v16 = 16'h0000;
			default: v16 = 16'($urandom);
		endcase
		write_reg(ghh_pkg::REG_TARGET_SPEED, {8'($urandom), v16});
		case ($urandom_range(9))
			0:       v16 = 16'd0;
			1:       v16 = 16'hFFFF;
			default: v16 = 16'($urandom_range(400, 10));
		endcase
		write_reg(ghh_pkg::REG_RUN_TIME_MS, {8'($urandom), v16});
		write_reg(ghh_pkg::REG_GAIN_P, pick_gain());
		write_reg(ghh_pkg::REG_GAIN_D, pick_gain());
		case ($urandom_range(5))
			0:       v16 = 16'd0;
			1:       v16 = 16'hFFFF;
			default: v16 = 16'($urandom);
		endcase
		write_reg(ghh_pkg::REG_RAMP_KEEP, {8'($urandom), v16});
		write_reg(ghh_pkg::REG_STOP_ON_LINE, 24'($urandom));
		cfg_close();
	endtask

	// mostly whole moves with random content, with restarts and idle ticks mixed in
	task automatic run_phase(int n_words, int hold_at);
		for (int i = 0; i < n_words; i++) begin
			if (!sb.running) begin
				if ($urandom_range(99) < 85)
					send_word(ghh_pkg::KIND_START, 16'($urandom), 1'($urandom));
				else
					send_word(ghh_pkg::KIND_TICK, pick_rate(), 1'($urandom));
			end else if ($urandom_range(99) < 4) begin
				send_word(ghh_pkg::KIND_START, 16'($urandom), 1'($urandom));
			end else begin
				send_word(ghh_pkg::KIND_TICK, pick_rate(), $urandom_range(99) < 8);
			end
			if (i == hold_at)
				stall_asks <= stall_asks + 1;
		end
	endtask

	initial begin
		sb               = new();
		calm             = 1'b0;
		stall_asks       = 0;
		stall_seen       = 0;
		stall_left       = 0;
		cycle_count      = 0;
		arst_n           = 1'b0;
		smp.valid        = 1'b0;
		smp.kind         = 1'b0;
		smp.gyro_rate    = '0;
		smp.line_reached = 1'b0;
		res.ready        = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick with no move armed
		send_word(ghh_pkg::KIND_TICK, 16'sh7FFF, 1'b1);
		drain();

		// short move on the reset gains, ending on time, then a tick after the end
		write_reg(ghh_pkg::REG_RUN_TIME_MS, 24'd30);
		cfg_close();
		send_word(ghh_pkg::KIND_START, 16'sh0000, 1'b0);
		send_word(ghh_pkg::KIND_TICK, 16'sh7FFF, 1'b0);
		send_word(ghh_pkg::KIND_TICK, 16'sh8000, 1'b0);
		send_word(ghh_pkg::KIND_TICK, 16'sh0000, 1'b1);
		send_word(ghh_pkg::KIND_TICK, 16'sh0001, 1'b0);
		drain();

		// full gains, instant ramp, line stop armed
		write_reg(ghh_pkg::REG_TARGET_SPEED, 24'h00_7FFF);
		write_reg(ghh_pkg::REG_GAIN_P, 24'hFF_FFFF);
		write_reg(ghh_pkg::REG_GAIN_D, 24'hFF_FFFF);
		write_reg(ghh_pkg::REG_RAMP_KEEP, 24'd0);
		write_reg(ghh_pkg::REG_STOP_ON_LINE, 24'd1);
		write_reg(ghh_pkg::REG_RUN_TIME_MS, 24'h00_FFFF);
		cfg_close();
		send_word(ghh_pkg::KIND_START, 16'shFFFF, 1'b1);
		send_word(ghh_pkg::KIND_TICK, 16'sh8000, 1'b0);
		send_word(ghh_pkg::KIND_TICK, 16'sh7FFF, 1'b1);
		drain();

		// most negative speed, slowest ramp, no gains; line ignored; restart mid-move
		write_reg(ghh_pkg::REG_TARGET_SPEED, 24'hFF_8000);
		write_reg(ghh_pkg::REG_RAMP_KEEP, 24'h00_FFFF);
		write_reg(ghh_pkg::REG_STOP_ON_LINE, 24'hFF_FFFE);
		write_reg(ghh_pkg::REG_GAIN_P, 24'd0);
		write_reg(ghh_pkg::REG_GAIN_D, 24'd0);
		cfg_close();
		send_word(ghh_pkg::KIND_START, 16'sh7FFF, 1'b0);
		send_word(ghh_pkg::KIND_TICK, 16'sh7FFF, 1'b1);
		send_word(ghh_pkg::KIND_START, 16'sh8000, 1'b1);
		send_word(ghh_pkg::KIND_TICK, 16'sh8000, 1'b0);
		drain();

		// zero speed ends at once
		write_reg(ghh_pkg::REG_TARGET_SPEED, 24'hFF_0000);
		cfg_close();
		send_word(ghh_pkg::KIND_START, 16'sh1234, 1'b1);
		send_word(ghh_pkg::KIND_TICK, 16'sh4321, 1'b0);
		drain();

		// zero time ends at once; a write to the spare index changes nothing
		write_reg(ghh_pkg::REG_TARGET_SPEED, 24'd5);
		write_reg(ghh_pkg::REG_RUN_TIME_MS, 24'hFF_0000);
		write_reg(SPARE_REG, 24'hFF_FFFF);
		cfg_close();
		send_word(ghh_pkg::KIND_START, 16'sh0000, 1'b0);
		send_word(ghh_pkg::KIND_TICK, 16'sh7FFF, 1'b1);
		drain();

		// random phases; one holds the result side off, one runs with no idling
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			calm <= (ph == 5);
			run_phase(45, (ph == 2) ? 6 : -1);
			drain();
		end
		calm <= 1'b0;

		// long move at full heading gain: the heading term drives both sides to their limits
		write_reg(ghh_pkg::REG_GAIN_P, 24'hFF_FFFF);
		write_reg(ghh_pkg::REG_RUN_TIME_MS, 24'h00_FFFF);
		write_reg(ghh_pkg::REG_STOP_ON_LINE, 24'd0);
		write_reg(ghh_pkg::REG_TARGET_SPEED, 24'($urandom_range(2000, 1)));
		cfg_close();
		send_word(ghh_pkg::KIND_START, 16'($urandom), 1'($urandom));
		repeat (40)
			send_word(ghh_pkg::KIND_TICK, 16'(32767 - $urandom_range(400)), 1'($urandom));
		drain();

		repeat (8) @(posedge clk);
		sb.close_out();
		if (sb.fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// File: sim.f
sv/ghh_pkg.sv
sv/ghh_sample_if.sv
sv/ghh_result_if.sv
sv/ghh_cfg_if.sv
sv/ghh_cfg_regs.sv
sv/ghh_track.sv
sv/ghh_corr.sv
sv/ghh_drive_out.sv
sv/gyro_heading_hold_drive_unit.sv
test/tb.sv
